// File: src/opgm_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the OFDM pilot grid mapper.
// No dependencies; imported by every module of the block.
package opgm_pkg;

    localparam int MAX_SUBCARRIERS = 4096;
    localparam int MAX_SYMBOLS     = 1024;
    localparam int SAMPLE_WIDTH    = 16;

    localparam int NSC_W  = 13;   // config width of subcarrier sizes
    localparam int NSYM_W = 11;   // config width of symbol sizes
    localparam int SC_W   = 12;   // subcarrier counter width
    localparam int SYM_W  = 10;   // symbol counter width
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_SUBCARRIERS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_SYMBOLS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PILOT_SPACING   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PILOT_PERIOD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PILOT_REAL      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PILOT_IMAG      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION       = 3'd6;

    localparam logic DIR_MAP   = 1'b0;
    localparam logic DIR_UNMAP = 1'b1;

    // Effective (clamped) configuration
    typedef struct packed {
        logic [NSC_W-1:0]               nsc;
        logic [NSYM_W-1:0]              nsym;
        logic [NSC_W-1:0]               spc;
        logic [NSYM_W-1:0]              per;
        logic signed [SAMPLE_WIDTH-1:0] pilot_real;
        logic signed [SAMPLE_WIDTH-1:0] pilot_imag;
        logic                           direction;
    } cfg_t;

    // Position of the current grid cell
    typedef struct packed {
        logic [SC_W-1:0]  subcarrier;
        logic [SYM_W-1:0] symbol;
        logic             pilot_hit;
        logic             frame_end;
    } pos_t;

    function automatic logic [NSC_W-1:0] clamp_sc(input logic [NSC_W-1:0] v);
        logic [NSC_W-1:0] r;
        if (v == '0) begin
            r = NSC_W'(1);
        end else if (v > NSC_W'(MAX_SUBCARRIERS)) begin
            r = NSC_W'(MAX_SUBCARRIERS);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [NSYM_W-1:0] clamp_sym(input logic [NSYM_W-1:0] v);
        logic [NSYM_W-1:0] r;
        if (v == '0) begin
            r = NSYM_W'(1);
        end else if (v > NSYM_W'(MAX_SYMBOLS)) begin
            r = NSYM_W'(MAX_SYMBOLS);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// File: src/ofdm_pilot_grid_mapper_unit.sv
`timescale 1ns / 1ps
// OFDM pilot grid mapper: walks the grid one cell per item, symbol-major.
// Depends on opgm_pkg, opgm_cfg_regs, opgm_grid_pos, opgm_cell_out.
//
// Input channel (s_*): one item per grid cell. In map mode it offers a data
// symbol (s_data_present); a pilot cell ignores it and emits the pilot, a
// data cell emits the symbol or zero. In unmap mode every cell is passed
// through and flagged as pilot or data.
// Result channel (m_*): one item per input item, with its grid position and
// an end-of-frame flag on the last cell of the frame.
// Configuration: cfg_we/cfg_addr/cfg_wdata write one register per cycle;
// write only while the block is idle.
// The result is registered: m_valid rises in the cycle after input accept.
// Throughput is one item per cycle while m_ready is high; the output register
// is refilled in the same cycle it is taken, so s_ready = !m_valid || m_ready.
// A stalled receiver holds m_* steady and backs up s_ready after one item.
// Reset (aresetn low, synchronous) restores the default grid (64 x 14, pilot
// spacing 4, period 1, pilot 32767+0j, map mode) and returns to cell (0,0).
module ofdm_pilot_grid_mapper_unit
    import opgm_pkg::*;
(
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [CFG_IDX_W-1:0]           cfg_addr,
    input  logic [CFG_DATA_W-1:0]          cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_data_present,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample_real,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample_imag,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_cell_real,
    output logic signed [SAMPLE_WIDTH-1:0] m_cell_imag,
    output logic                           m_cell_is_pilot,
    output logic                           m_data_taken,
    output logic [SYM_W-1:0]               m_symbol_index,
    output logic [SC_W-1:0]                m_subcarrier_index,
    output logic                           m_frame_end
);

    cfg_t cfg;
    pos_t pos;
    logic accept;

    assign s_ready = !m_valid || m_ready;
    assign accept  = s_valid && s_ready;

    opgm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    opgm_grid_pos u_pos (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (accept),
        .cfg     (cfg),
        .pos     (pos)
    );

    opgm_cell_out u_out (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .load             (accept),
        .out_ready        (m_ready),
        .cfg              (cfg),
        .pos              (pos),
        .data_present     (s_data_present),
        .sample_real      (s_sample_real),
        .sample_imag      (s_sample_imag),
        .out_valid        (m_valid),
        .cell_real        (m_cell_real),
        .cell_imag        (m_cell_imag),
        .cell_is_pilot    (m_cell_is_pilot),
        .data_taken       (m_data_taken),
        .symbol_index     (m_symbol_index),
        .subcarrier_index (m_subcarrier_index),
        .frame_end        (m_frame_end)
    );

endmodule

// File: src/opgm_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file with reset defaults and size clamping.
// Depends on opgm_pkg.
module opgm_cfg_regs
    import opgm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    logic [NSC_W-1:0]               nsc_reg;
    logic [NSYM_W-1:0]              nsym_reg;
    logic [NSC_W-1:0]               spc_reg;
    logic [NSYM_W-1:0]              per_reg;
    logic signed [SAMPLE_WIDTH-1:0] pilot_real_reg;
    logic signed [SAMPLE_WIDTH-1:0] pilot_imag_reg;
    logic                           direction_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nsc_reg        <= NSC_W'(64);
            nsym_reg       <= NSYM_W'(14);
            spc_reg        <= NSC_W'(4);
            per_reg        <= NSYM_W'(1);
            pilot_real_reg <= SAMPLE_WIDTH'(32767);
            pilot_imag_reg <= '0;
            direction_reg  <= DIR_MAP;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_NUM_SUBCARRIERS: nsc_reg        <= cfg_wdata[NSC_W-1:0];
                REG_NUM_SYMBOLS:     nsym_reg       <= cfg_wdata[NSYM_W-1:0];
                REG_PILOT_SPACING:   spc_reg        <= cfg_wdata[NSC_W-1:0];
                REG_PILOT_PERIOD:    per_reg        <= cfg_wdata[NSYM_W-1:0];
                REG_PILOT_REAL:      pilot_real_reg <= cfg_wdata[SAMPLE_WIDTH-1:0];
                REG_PILOT_IMAG:      pilot_imag_reg <= cfg_wdata[SAMPLE_WIDTH-1:0];
                REG_DIRECTION:       direction_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // zero sizes act as 1, oversize saturates
    always_comb begin
        cfg.nsc        = clamp_sc(nsc_reg);
        cfg.nsym       = clamp_sym(nsym_reg);
        cfg.spc        = clamp_sc(spc_reg);
        cfg.per        = clamp_sym(per_reg);
        cfg.pilot_real = pilot_real_reg;
        cfg.pilot_imag = pilot_imag_reg;
        cfg.direction  = direction_reg;
    end

endmodule

// File: src/opgm_grid_pos.sv
`timescale 1ns / 1ps
// Grid position counters and pilot lattice phases; advance one cell per item.
// Depends on opgm_pkg.
module opgm_grid_pos
    import opgm_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic advance,
    input  cfg_t cfg,
    output pos_t pos
);

    logic [SC_W-1:0]  sc_reg,  sc_next;
    logic [SYM_W-1:0] sym_reg, sym_next;
    logic [SC_W-1:0]  sp_reg,  sp_next;
    logic [SYM_W-1:0] pp_reg,  pp_next;

    logic [NSC_W-1:0]  sc_inc, sp_inc;
    logic [NSYM_W-1:0] sym_inc, pp_inc;
    logic              last_sc, last_sym;

    always_comb begin
        sc_inc   = {1'b0, sc_reg} + NSC_W'(1);
        sym_inc  = {1'b0, sym_reg} + NSYM_W'(1);
        sp_inc   = {1'b0, sp_reg} + NSC_W'(1);
        pp_inc   = {1'b0, pp_reg} + NSYM_W'(1);
        // counters left past a shrunk limit wrap on their next advance
        last_sc  = sc_inc >= cfg.nsc;
        last_sym = sym_inc >= cfg.nsym;

        sc_next  = sc_reg;
        sym_next = sym_reg;
        sp_next  = sp_reg;
        pp_next  = pp_reg;
        if (advance) begin
            if (last_sc) begin
                sc_next = '0;
                sp_next = '0;
                if (last_sym) begin
                    sym_next = '0;
                    pp_next  = '0;
                end else begin
                    sym_next = sym_inc[SYM_W-1:0];
                    pp_next  = (pp_inc >= cfg.per) ? '0 : pp_inc[SYM_W-1:0];
                end
            end else begin
                sc_next = sc_inc[SC_W-1:0];
                sp_next = (sp_inc >= cfg.spc) ? '0 : sp_inc[SC_W-1:0];
            end
        end

        pos.subcarrier = sc_reg;
        pos.symbol     = sym_reg;
        pos.pilot_hit  = (sp_reg == '0) && (pp_reg == '0);
        pos.frame_end  = last_sc && last_sym;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sc_reg  <= '0;
            sym_reg <= '0;
            sp_reg  <= '0;
            pp_reg  <= '0;
        end else begin
            sc_reg  <= sc_next;
            sym_reg <= sym_next;
            sp_reg  <= sp_next;
            pp_reg  <= pp_next;
        end
    end

endmodule

// File: src/opgm_cell_out.sv
`timescale 1ns / 1ps
// Cell select (pilot / data / zero / pass-through) and result register.
// Depends on opgm_pkg.
module opgm_cell_out
    import opgm_pkg::*;
(
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load,
    input  logic                           out_ready,
    input  cfg_t                           cfg,
    input  pos_t                           pos,
    input  logic                           data_present,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_real,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_imag,
    output logic                           out_valid,
    output logic signed [SAMPLE_WIDTH-1:0] cell_real,
    output logic signed [SAMPLE_WIDTH-1:0] cell_imag,
    output logic                           cell_is_pilot,
    output logic                           data_taken,
    output logic [SYM_W-1:0]               symbol_index,
    output logic [SC_W-1:0]                subcarrier_index,
    output logic                           frame_end
);

    logic                           valid_reg, valid_next;
    logic signed [SAMPLE_WIDTH-1:0] re_reg, re_next;
    logic signed [SAMPLE_WIDTH-1:0] im_reg, im_next;
    logic                           taken_reg, taken_next;
    pos_t                           pos_reg;

    always_comb begin
        re_next    = '0;
        im_next    = '0;
        taken_next = 1'b0;
        priority if (cfg.direction == DIR_UNMAP) begin
            re_next    = sample_real;
            im_next    = sample_imag;
            taken_next = !pos.pilot_hit;
        end else if (pos.pilot_hit) begin
            re_next = cfg.pilot_real;
            im_next = cfg.pilot_imag;
        end else if (data_present) begin
            re_next    = sample_real;
            im_next    = sample_imag;
            taken_next = 1'b1;
        end else begin
            re_next = '0;   // empty data cell
        end

        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            re_reg    <= re_next;
            im_reg    <= im_next;
            taken_reg <= taken_next;
            pos_reg   <= pos;
        end
    end

    assign out_valid        = valid_reg;
    assign cell_real        = re_reg;
    assign cell_imag        = im_reg;
    assign cell_is_pilot    = pos_reg.pilot_hit;
    assign data_taken       = taken_reg;
    assign symbol_index     = pos_reg.symbol;
    assign subcarrier_index = pos_reg.subcarrier;
    assign frame_end        = pos_reg.frame_end;

endmodule
